>>> sv/absd_pkg.sv
package absd_pkg;

    localparam int unsigned FILE_SIZE_W = 31;
    localparam int unsigned SKIP_W      = 31;
    localparam int unsigned KEY_W       = 7;
    localparam int unsigned POS_A_W     = 5;
    localparam int unsigned POS_B_W     = 4;
    localparam int unsigned DIV_CNT_W   = 3;
    localparam int unsigned MOD_W       = 11;

    localparam logic KIND_DATA       = 1'b0;
    localparam logic KIND_REPOSITION = 1'b1;

    localparam logic REG_FILE_SIZE      = 1'b0;
    localparam logic REG_DECRYPT_ENABLE = 1'b1;

    localparam logic [POS_A_W-1:0]   POS_A_LAST  = 5'd19;
    localparam logic [POS_B_W-1:0]   POS_B_LAST  = 4'd11;
    localparam logic [POS_A_W-1:0]   POS_A_FIRST = 5'd1;
    localparam logic [POS_B_W-1:0]   POS_B_FIRST = 4'd1;
    localparam logic [DIV_CNT_W-1:0] KEY_MSB     = 3'd6;

    localparam logic [7:0] TAB_A [0:31] = '{
        8'h34, 8'h52, 8'h61, 8'h53, 8'h39, 8'h44, 8'h37, 8'h4B,
        8'h61, 8'h45, 8'h62, 8'h78, 8'h63, 8'h70, 8'h32, 8'h6F,
        8'h35, 8'h72, 8'h36, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [7:0] TAB_B [0:15] = '{
        8'h33, 8'h74, 8'h52, 8'h61, 8'h55, 8'h78, 8'h4C, 8'h6D,
        8'h45, 8'h61, 8'h53, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SKIP
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [POS_A_W-1:0] pos_a;
        logic [POS_B_W-1:0] pos_b;
        logic               swap;
    } key_state_t;

    typedef struct packed {
        logic load_data;
        logic start_repos;
        logic div_step;
        logic skip_step;
    } cmd_t;

    typedef struct packed {
        logic decrypt_enable;
        logic div_last;
        logic skip_zero;
        logic skip_one;
    } status_t;

    // Remainder of a key number by a small constant, by shifted compare and subtract.
    function automatic logic [3:0] mod_small(input logic [KEY_W-1:0] v, input logic [3:0] d);
        logic [MOD_W-1:0] r;
        logic [MOD_W-1:0] sh;
        r = {{(MOD_W-KEY_W){1'b0}}, v};
        for (int i = KEY_W - 1; i >= 0; i--)
        begin
            sh = {{(MOD_W-4){1'b0}}, d} << i;
            if (r >= sh)
            begin
                r = r - sh;
            end
        end
        return r[3:0];
    endfunction

    function automatic key_state_t advance(input key_state_t s);
        key_state_t n;
        logic       pass_a;
        logic       pass_b;
        n       = s;
        n.pos_a = s.pos_a + POS_A_FIRST;
        n.pos_b = s.pos_b + POS_B_FIRST;
        pass_a  = n.pos_a > POS_A_LAST;
        pass_b  = n.pos_b > POS_B_LAST;
        if (!(pass_a && pass_b))
        begin
            if (pass_a)
            begin
                n.pos_a = POS_A_FIRST;
                n.swap  = ~n.swap;
            end
            if (pass_b)
            begin
                n.pos_b = POS_B_FIRST;
                n.swap  = ~n.swap;
            end
        end
        else
        begin
            n.key = s.key + 7'd1;
            if (s.swap)
            begin
                n.swap  = 1'b0;
                n.pos_a = {1'b0, mod_small(n.key, 4'd12)} + 5'd6;
                n.pos_b = mod_small(n.key, 4'd5) + 4'd4;
            end
            else
            begin
                n.swap  = 1'b1;
                n.pos_a = {1'b0, mod_small(n.key, 4'd15)} + 5'd3;
                n.pos_b = mod_small(n.key, 4'd7) + 4'd1;
            end
        end
        return n;
    endfunction

endpackage

>>> sv/archive_byte_stream_decryptor.sv
// Each data byte appears in the cycle after acceptance; one byte a cycle while out_stall is low.
// A reposition request reseeds the key state (a bit-serial remainder of the key number) and
// then steps the keystream skip_count positions, one position a cycle.
// No request is accepted during a reposition; a disabled reposition finishes in its own cycle.
// An asynchronous active-low reset zeroes the key, resets its positions and sets decryption on.
module archive_byte_stream_decryptor
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [absd_pkg::FILE_SIZE_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [7:0]                        cipher_byte,
    input  logic [absd_pkg::SKIP_W-1:0]       skip_count,
    input  logic                              last_of_read,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        plain_byte,
    output logic                              last_out
);

    absd_pkg::cmd_t    cmd;
    absd_pkg::status_t status;

    absd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    absd_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cipher_byte  (cipher_byte),
        .skip_count   (skip_count),
        .last_of_read (last_of_read),
        .cmd          (cmd),
        .status       (status),
        .plain_byte   (plain_byte),
        .last_out     (last_out)
    );

endmodule

>>> sv/absd_ctrl.sv
module absd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               kind,
    input  logic               out_stall,
    input  absd_pkg::status_t  status,
    output logic               in_stall,
    output logic               out_valid,
    output absd_pkg::cmd_t     cmd
);

    absd_pkg::state_t state_reg;
    absd_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             can_take;
    logic             in_acc;

    assign can_take  = (state_reg == absd_pkg::ST_IDLE) && (!out_valid_reg || !out_stall);
    assign in_acc    = in_valid && can_take;
    assign in_stall  = !can_take;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            absd_pkg::ST_IDLE:
            begin
                if (cmd.start_repos)
                begin
                    state_next = absd_pkg::ST_DIV;
                end
            end
            absd_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = absd_pkg::ST_SKIP;
                end
            end
            absd_pkg::ST_SKIP:
            begin
                if (status.skip_zero || status.skip_one)
                begin
                    state_next = absd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = absd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load_data   = 1'b0;
        cmd.start_repos = 1'b0;
        cmd.div_step    = 1'b0;
        cmd.skip_step   = 1'b0;
        unique case (state_reg)
            absd_pkg::ST_IDLE:
            begin
                cmd.load_data   = in_acc && (kind == absd_pkg::KIND_DATA);
                cmd.start_repos = in_acc && (kind == absd_pkg::KIND_REPOSITION)
                                  && status.decrypt_enable;
            end
            absd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            absd_pkg::ST_SKIP:
            begin
                cmd.skip_step = !status.skip_zero;
            end
            default:
            begin
                cmd.load_data = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_data)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= absd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/absd_datapath.sv
module absd_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic                                 cfg_index,
    input  logic [absd_pkg::FILE_SIZE_W-1:0]     cfg_data,
    input  logic [7:0]                           cipher_byte,
    input  logic [absd_pkg::SKIP_W-1:0]          skip_count,
    input  logic                                 last_of_read,
    input  absd_pkg::cmd_t                       cmd,
    output absd_pkg::status_t                    status,
    output logic [7:0]                           plain_byte,
    output logic                                 last_out
);

    logic [absd_pkg::FILE_SIZE_W-1:0] file_size_reg;
    logic [absd_pkg::FILE_SIZE_W-1:0] file_size_next;
    logic                             decrypt_enable_reg;
    logic                             decrypt_enable_next;
    absd_pkg::key_state_t             ks_reg;
    absd_pkg::key_state_t             ks_next;
    absd_pkg::key_state_t             ks_adv;
    logic [absd_pkg::SKIP_W-1:0]      skip_left_reg;
    logic [absd_pkg::SKIP_W-1:0]      skip_left_next;
    logic [3:0]                       rem_reg;
    logic [3:0]                       rem_next;
    logic [absd_pkg::DIV_CNT_W-1:0]   div_cnt_reg;
    logic [absd_pkg::DIV_CNT_W-1:0]   div_cnt_next;
    logic [7:0]                       plain_byte_reg;
    logic [7:0]                       plain_byte_next;
    logic                             last_out_reg;
    logic                             last_out_next;
    logic [absd_pkg::KEY_W-1:0]       seed_key;
    logic [4:0]                       trial;
    logic [3:0]                       trial_rem;
    logic [7:0]                       mixed;
    logic [7:0]                       swapped;

    assign seed_key = file_size_reg[8:2];
    assign ks_adv   = absd_pkg::advance(ks_reg);
    assign trial    = {rem_reg, ks_reg.key[div_cnt_reg]};
    assign trial_rem = (trial >= {1'b0, ks_reg.pos_b}) ? 4'(trial - {1'b0, ks_reg.pos_b})
                                                       : trial[3:0];
    assign mixed    = cipher_byte ^ absd_pkg::TAB_B[ks_reg.pos_b] ^ {1'b0, ks_reg.key};
    assign swapped  = ks_reg.swap ? {mixed[3:0], mixed[7:4]} : mixed;

    assign status.decrypt_enable = decrypt_enable_reg;
    assign status.div_last       = (div_cnt_reg == '0);
    assign status.skip_zero      = (skip_left_reg == '0);
    assign status.skip_one       = (skip_left_reg == absd_pkg::SKIP_W'(1));

    assign plain_byte = plain_byte_reg;
    assign last_out   = last_out_reg;

    always_comb
    begin
        file_size_next      = file_size_reg;
        decrypt_enable_next = decrypt_enable_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                absd_pkg::REG_FILE_SIZE:      file_size_next      = cfg_data;
                absd_pkg::REG_DECRYPT_ENABLE: decrypt_enable_next = cfg_data[0];
                default:                      file_size_next      = file_size_reg;
            endcase
        end
    end

    always_comb
    begin
        ks_next         = ks_reg;
        skip_left_next  = skip_left_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        plain_byte_next = plain_byte_reg;
        last_out_next   = last_out_reg;
        if (cmd.load_data)
        begin
            last_out_next = last_of_read;
            if (decrypt_enable_reg)
            begin
                plain_byte_next = swapped ^ absd_pkg::TAB_A[ks_reg.pos_a];
                ks_next         = ks_adv;
            end
            else
            begin
                plain_byte_next = cipher_byte;
            end
        end
        if (cmd.start_repos)
        begin
            ks_next.key    = seed_key;
            ks_next.pos_b  = absd_pkg::mod_small(seed_key, 4'd9) + 4'd1;
            ks_next.swap   = 1'b0;
            rem_next       = '0;
            div_cnt_next   = absd_pkg::KEY_MSB;
            skip_left_next = skip_count;
        end
        if (cmd.div_step)
        begin
            rem_next     = trial_rem;
            div_cnt_next = div_cnt_reg - 3'd1;
            if (status.div_last)
            begin
                ks_next.pos_a = {1'b0, trial_rem} + 5'd1;
            end
        end
        if (cmd.skip_step)
        begin
            ks_next        = ks_adv;
            skip_left_next = skip_left_reg - absd_pkg::SKIP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg      <= '0;
            decrypt_enable_reg <= 1'b1;
            ks_reg.key         <= '0;
            ks_reg.pos_a       <= absd_pkg::POS_A_FIRST;
            ks_reg.pos_b       <= absd_pkg::POS_B_FIRST;
            ks_reg.swap        <= 1'b0;
            skip_left_reg      <= '0;
            rem_reg            <= '0;
            div_cnt_reg        <= '0;
        end
        else
        begin
            file_size_reg      <= file_size_next;
            decrypt_enable_reg <= decrypt_enable_next;
            ks_reg             <= ks_next;
            skip_left_reg      <= skip_left_next;
            rem_reg            <= rem_next;
            div_cnt_reg        <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plain_byte_reg <= plain_byte_next;
        last_out_reg   <= last_out_next;
    end

endmodule

>>> bench/tb_archive_byte_stream_decryptor.sv
`timescale 1ns / 1ps

module tb_archive_byte_stream_decryptor;

    localparam string KEY_TEXT_A = "4RaS9D7KaEbxcp2o5r6t";
    localparam string KEY_TEXT_B = "3tRaUxLmEaSn";
    localparam int    QUIET_LIMIT = 20000;
    localparam int    HOLD_CYCLES = 300;
    localparam int    PHASE_ITEMS = 50;

    typedef struct {
        logic [7:0] plain;
        logic       last;
    } plain_due_t;

    class decrypt_tracker;
        logic [30:0]  file_size;
        logic         enable;
        logic [6:0]   key;
        logic [4:0]   pos_a;
        logic [3:0]   pos_b;
        logic         swap;
        plain_due_t   plain_due[$];
        int           mismatches;

        function new();
            file_size  = '0;
            enable     = 1'b1;
            key        = '0;
            pos_a      = 5'd1;
            pos_b      = 4'd1;
            swap       = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic idx, logic [30:0] value);
            if (idx == absd_pkg::REG_FILE_SIZE)
            begin
                file_size = value;
            end
            else
            begin
                enable = value[0];
            end
        endfunction

        function logic [7:0] key_a_at(logic [4:0] p);
            if (p < KEY_TEXT_A.len())
            begin
                return KEY_TEXT_A[p];
            end
            return 8'h00;
        endfunction

        function logic [7:0] key_b_at(logic [3:0] p);
            if (p < KEY_TEXT_B.len())
            begin
                return KEY_TEXT_B[p];
            end
            return 8'h00;
        endfunction

        function void step_key();
            logic [4:0] na;
            logic [3:0] nb;
            na = pos_a + 5'd1;
            nb = pos_b + 4'd1;
            if (na <= 5'd19 || nb <= 4'd11)
            begin
                if (na > 5'd19)
                begin
                    na   = 5'd1;
                    swap = ~swap;
                end
                if (nb > 4'd11)
                begin
                    nb   = 4'd1;
                    swap = ~swap;
                end
                pos_a = na;
                pos_b = nb;
            end
            else
            begin
                key = key + 7'd1;
                if (swap)
                begin
                    swap  = 1'b0;
                    pos_a = 5'(key % 12 + 6);
                    pos_b = 4'(key % 5 + 4);
                end
                else
                begin
                    swap  = 1'b1;
                    pos_a = 5'(key % 15 + 3);
                    pos_b = 4'(key % 7 + 1);
                end
            end
        endfunction

        function void note_request(logic k, logic [7:0] cb, logic [30:0] sk, logic lr);
            plain_due_t e;
            logic [7:0] d;
            if (k == absd_pkg::KIND_REPOSITION)
            begin
                if (enable)
                begin
                    key   = file_size[8:2];
                    pos_b = 4'(key % 9 + 1);
                    pos_a = 5'(key % pos_b + 1);
                    swap  = 1'b0;
                    for (longint unsigned i = 0; i < sk; i++)
                    begin
                        step_key();
                    end
                end
                return;
            end
            if (enable)
            begin
                d = cb ^ key_b_at(pos_b) ^ {1'b0, key};
                if (swap)
                begin
                    d = {d[3:0], d[7:4]};
                end
                d = d ^ key_a_at(pos_a);
                step_key();
            end
            else
            begin
                d = cb;
            end
            e.plain = d;
            e.last  = lr;
            plain_due.push_back(e);
        endfunction

        function void check_plain(logic [7:0] pb, logic lo);
            plain_due_t e;
            if (plain_due.size() == 0)
            begin
                $error("plain_byte %02h arrived with no request outstanding", pb);
                mismatches++;
                return;
            end
            e = plain_due.pop_front();
            if (pb !== e.plain)
            begin
                $error("plain_byte: expected %02h, actual %02h", e.plain, pb);
                mismatches++;
            end
            if (lo !== e.last)
            begin
                $error("last_out: expected %0b, actual %0b", e.last, lo);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    logic        cfg_index    = absd_pkg::REG_FILE_SIZE;
    logic [30:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        kind         = absd_pkg::KIND_DATA;
    logic [7:0]  cipher_byte  = '0;
    logic [30:0] skip_count   = '0;
    logic        last_of_read = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  plain_byte;
    logic        last_out;

    decrypt_tracker tracker = new();
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    longint pending_skip = 0;

    archive_byte_stream_decryptor u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .cipher_byte  (cipher_byte),
        .skip_count   (skip_count),
        .last_of_read (last_of_read),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_byte   (plain_byte),
        .last_out     (last_out)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_plain(plain_byte, last_out);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [30:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_request(input logic k, input logic [7:0] cb, input logic [30:0] sk,
                                input logic lr);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        cipher_byte  <= cb;
        skip_count   <= sk;
        last_of_read <= lr;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_skip = (k == absd_pkg::KIND_REPOSITION && tracker.enable) ? longint'(sk) : 0;
        tracker.note_request(k, cb, sk, lr);
    endtask

    task automatic send_data(input logic [7:0] cb, input logic lr);
        send_request(absd_pkg::KIND_DATA, cb, 31'($urandom), lr);
    endtask

    task automatic send_reposition(input logic [30:0] sk);
        send_request(absd_pkg::KIND_REPOSITION, 8'($urandom), sk, 1'($urandom_range(1)));
    endtask

    task automatic send_random_request();
        logic [30:0] sk;
        if ($urandom_range(99) < 10)
        begin
            if (!tracker.enable)
            begin
                sk = 31'($urandom);
            end
            else if ($urandom_range(9) == 0)
            begin
                sk = 31'($urandom_range(600));
            end
            else
            begin
                sk = 31'($urandom_range(40));
            end
            send_reposition(sk);
        end
        else
        begin
            send_data(8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.plain_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12 + pending_skip) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            1:
            begin
                send_gap_pct = 58;
                stall_pct    = 0;
            end
            2:
            begin
                send_gap_pct = 0;
                stall_pct    = 58;
            end
            default:
            begin
                send_gap_pct = 31;
                stall_pct    = 31;
            end
        endcase
    endtask

    initial
    begin
        logic [30:0] size_value;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idling(0);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
        for (int i = 0; i < 10; i++)
        begin
            send_data(8'($urandom), 1'(i % 2));
        end
        send_reposition(31'd0);
        send_data(8'hA5, 1'b0);
        send_reposition(31'd1);
        send_data(8'h5A, 1'b1);
        send_reposition(31'd200);
        send_data(8'h3C, 1'b0);
        drain_block();

        write_reg(absd_pkg::REG_FILE_SIZE, 31'h7FFF_FFFF);
        set_idling(3);
        send_reposition(31'd3000);
        send_data(8'hFF, 1'b1);
        send_data(8'h00, 1'b0);
        drain_block();

        write_reg(absd_pkg::REG_DECRYPT_ENABLE, 31'd0);
        send_data(8'h00, 1'b0);
        send_data(8'hFF, 1'b1);
        send_reposition(31'h7FFF_FFFF);
        send_data(8'h81, 1'b0);
        drain_block();
        write_reg(absd_pkg::REG_DECRYPT_ENABLE, 31'd1);
        send_data(8'h7E, 1'b1);
        drain_block();

        for (int p = 0; p < 8; p++)
        begin
            set_idling(p % 4);
            if (p == 1)
            begin
                size_value = '0;
            end
            else if (p == 2)
            begin
                size_value = 31'h7FFF_FFFF;
            end
            else
            begin
                size_value = 31'($urandom);
            end
            write_reg(absd_pkg::REG_FILE_SIZE, size_value);
            write_reg(absd_pkg::REG_DECRYPT_ENABLE, (p == 6) ? 31'd0 : 31'd1);
            if (p == 4)
            begin
                hold_asked++;
            end
            send_reposition(31'($urandom_range(30)));
            repeat (PHASE_ITEMS) send_random_request();
            drain_block();
        end

        if (tracker.mismatches == 0 && tracker.plain_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
